[rtl/epps_pkg.sv]
// ----------------------------------------------------------------------------
// epps_pkg: shared types and constants
// Job record passed from the capture front end to the speed/PID back end,
// register indexes, event codes and reset values.
// ----------------------------------------------------------------------------
package epps_pkg;

    // event codes
    localparam logic [1:0] MODE_PHASE_A  = 2'd0;
    localparam logic [1:0] MODE_PHASE_B  = 2'd1;
    localparam logic [1:0] MODE_OVERFLOW = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_KP    = 3'd0;
    localparam logic [2:0] REG_KI    = 3'd1;
    localparam logic [2:0] REG_KD    = 3'd2;
    localparam logic [2:0] REG_CLOCK = 3'd3;
    localparam logic [2:0] REG_SCALE = 3'd4;

    // reset values
    localparam logic [15:0] KP_RESET    = 16'd2048;
    localparam logic [15:0] KI_RESET    = 16'd819;
    localparam logic [15:0] KD_RESET    = 16'd205;
    localparam logic [31:0] CLOCK_RESET = 32'd100000000;
    localparam logic [31:0] SCALE_RESET = 32'd65536;

    localparam logic [31:0] COUNTER_MODULUS_DEFAULT = 32'd65536;

    // one measured pulse period waiting for the back end
    typedef struct packed {
        logic [31:0] period;
        logic [15:0] target;
        logic        dir;
    } job_t;

endpackage

[rtl/epps_queue.sv]
// ----------------------------------------------------------------------------
// epps_queue: two-entry job queue
// Decouples the capture front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module epps_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  epps_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output epps_pkg::job_t pop_data
);
    import epps_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/epps_front.sv]
// ----------------------------------------------------------------------------
// epps_front: capture front end
// Classifies timer events, counts overflows and pairs phase-A captures into
// pulse periods that are queued for the back end.
// ----------------------------------------------------------------------------
module epps_front
#(
    parameter logic [31:0] COUNTER_MODULUS = epps_pkg::COUNTER_MODULUS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    mode,
    input  logic [31:0]   capture_value,
    input  logic [15:0]   speed_setpoint,
    input  logic          direction,
    output logic          push,
    output epps_pkg::job_t push_data,
    input  logic          queue_full
);
    import epps_pkg::*;

    logic        pending_reg;
    logic [31:0] first_reg;
    logic [31:0] ovf_scaled_reg;   // overflow count times modulus, wrapping
    logic        accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept && (mode == MODE_PHASE_A) && pending_reg;

    // period of the pair closed by this capture
    assign push_data.period = capture_value + ovf_scaled_reg - first_reg;
    assign push_data.target = speed_setpoint;
    assign push_data.dir    = direction;

    // track capture pairing and overflow count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b0;
            first_reg      <= 32'd0;
            ovf_scaled_reg <= 32'd0;
        end
        else if (accept)
        begin
            case (mode)
                MODE_OVERFLOW:
                begin
                    ovf_scaled_reg <= ovf_scaled_reg + COUNTER_MODULUS;
                end
                MODE_PHASE_A:
                begin
                    if (!pending_reg)
                    begin
                        first_reg <= capture_value;
                    end
                    ovf_scaled_reg <= 32'd0;
                    pending_reg    <= ~pending_reg;
                end
                default:
                begin
                    // phase B and unused codes: drop
                end
            endcase
        end
    end

endmodule

[rtl/epps_back.sv]
// ----------------------------------------------------------------------------
// epps_back: speed and PID back end
// Divides clock by period bit-serially, scales to shaft speed, runs the PID
// with one multiply a cycle and holds the result in an output register.
// ----------------------------------------------------------------------------
module epps_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 queue_empty,
    input  epps_pkg::job_t       job,
    output logic                 pop,
    input  logic [15:0]          kp_gain,
    input  logic [15:0]          ki_gain,
    input  logic [15:0]          kd_gain,
    input  logic [31:0]          timer_clk_hz,
    input  logic [31:0]          speed_scale,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   drive_value,
    output logic                 direction_out,
    output logic [31:0]          period_count,
    output logic [31:0]          phase_frequency,
    output logic [15:0]          speed_meas
);
    import epps_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SPD  = 3'd3;
    localparam logic [2:0] ST_PID0 = 3'd4;
    localparam logic [2:0] ST_PID1 = 3'd5;
    localparam logic [2:0] ST_PID2 = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    logic [2:0]          state_reg;
    job_t                job_reg;
    logic [4:0]          cnt_reg;
    logic [31:0]         quo_reg;
    logic [31:0]         rem_reg;
    logic [31:0]         freq_reg;
    logic [63:0]         prod_reg;
    logic [15:0]         speed_reg;
    logic signed [31:0]  integ_reg;
    logic signed [16:0]  prev_reg;
    logic signed [17:0]  deriv_reg;
    logic signed [49:0]  acc_reg;
    logic                out_valid_reg;

    logic [32:0]         rem_sh;
    logic                ge;
    logic [31:0]         quo_next;
    logic signed [16:0]  err;
    logic signed [32:0]  integ_sum;
    logic signed [31:0]  integ_next;
    logic signed [49:0]  rounded;
    logic signed [37:0]  shifted;
    logic signed [31:0]  drive_next;
    logic                out_free;

    assign pop       = (state_reg == ST_IDLE) && !queue_empty;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // one restoring division step
    assign rem_sh   = {rem_reg, quo_reg[31]};
    assign ge       = (rem_sh >= {1'b0, job_reg.period});
    assign quo_next = {quo_reg[30:0], ge};

    // error and saturating integral
    assign err       = $signed({1'b0, job_reg.target}) - $signed({1'b0, speed_reg});
    assign integ_sum = {integ_reg[31], integ_reg} + 33'(err);
    always_comb
    begin
        if (integ_sum[32] != integ_sum[31])
        begin
            integ_next = integ_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            integ_next = integ_sum[31:0];
        end
    end

    // round to nearest and saturate
    assign rounded = acc_reg + 50'sd2048;
    assign shifted = rounded[49:12];
    always_comb
    begin
        if (shifted > 38'sh0_7FFF_FFFF)
        begin
            drive_next = 32'sh7FFF_FFFF;
        end
        else if (shifted < -38'sh0_8000_0000)
        begin
            drive_next = 32'sh8000_0000;
        end
        else
        begin
            drive_next = shifted[31:0];
        end
    end

    // sequence the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            integ_reg     <= 32'sd0;
            prev_reg      <= 17'sd0;
            cnt_reg       <= 5'd0;
        end
        else
        begin
            // load a new result or drop the one just transferred
            if ((state_reg == ST_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= 5'd0;
                    end
                end
                ST_DIV:
                begin
                    if (job_reg.period == 32'd0)
                    begin
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                        if (cnt_reg == 5'd31)
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:  state_reg <= ST_SPD;
                ST_SPD:  state_reg <= ST_PID0;
                ST_PID0:
                begin
                    integ_reg <= integ_next;
                    prev_reg  <= err;
                    state_reg <= ST_PID1;
                end
                ST_PID1: state_reg <= ST_PID2;
                ST_PID2: state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                job_reg <= job;
                quo_reg <= timer_clk_hz;
                rem_reg <= 32'd0;
            end
            ST_DIV:
            begin
                if (job_reg.period == 32'd0)
                begin
                    freq_reg <= 32'hFFFF_FFFF;
                end
                else
                begin
                    quo_reg <= quo_next;
                    rem_reg <= ge ? 32'(rem_sh - {1'b0, job_reg.period}) : rem_sh[31:0];
                    if (cnt_reg == 5'd31)
                    begin
                        freq_reg <= quo_next;
                    end
                end
            end
            ST_MUL:
            begin
                prod_reg <= 64'(freq_reg) * 64'(speed_scale);
            end
            ST_SPD:
            begin
                speed_reg <= (prod_reg[63:32] != 32'd0) ? 16'hFFFF : prod_reg[31:16];
            end
            ST_PID0:
            begin
                deriv_reg <= 18'(err) - 18'(prev_reg);
                acc_reg   <= 50'($signed({1'b0, kp_gain}) * err);
            end
            ST_PID1:
            begin
                acc_reg <= acc_reg + 50'($signed({1'b0, ki_gain}) * integ_reg);
            end
            ST_PID2:
            begin
                acc_reg <= acc_reg + 50'($signed({1'b0, kd_gain}) * deriv_reg);
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    drive_value     <= drive_next;
                    direction_out   <= job_reg.dir;
                    period_count    <= job_reg.period;
                    phase_frequency <= freq_reg;
                    speed_meas      <= speed_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/encoder_period_pid_speed.sv]
// ----------------------------------------------------------------------------
// encoder_period_pid_speed: encoder period capture with PID speed loop
// Pairs phase-A captures into pulse periods and drives a PID speed loop.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries timer events: phase-A capture,
//   phase-B capture (dropped) or counter overflow. Every other phase-A capture
//   closes a period and produces one result on the output channel
//   (out_valid / out_stall); other events produce none.
//   Events are taken one per cycle while the two-entry job queue has room.
//   out_valid rises once a closing capture has been transferred and has passed
//   through the queue, 32 bit-serial divider steps, one speed multiply, three
//   PID steps with one multiply each and one output load. A zero period skips
//   the divider steps. The back end takes a new job only after it has finished
//   the last one and returned to idle.
//   When the receiver stalls, the result holds in the output register, the
//   back end finishes its next job and waits, and in_stall rises once the
//   queue fills. Configuration writes (cfg_valid / cfg_ready, always ready)
//   are taken any time; change them only while the block is idle.
//   Reset clears pairing, overflow count, PID state and registers to defaults.
// ----------------------------------------------------------------------------
module encoder_period_pid_speed
#(
    parameter logic [31:0] COUNTER_MODULUS = epps_pkg::COUNTER_MODULUS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [31:0]        capture_value,
    input  logic [15:0]        speed_setpoint,
    input  logic               direction,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] drive_value,
    output logic               direction_out,
    output logic [31:0]        period_count,
    output logic [31:0]        phase_frequency,
    output logic [15:0]        speed_meas,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import epps_pkg::*;

    logic [15:0] kp_reg;
    logic [15:0] ki_reg;
    logic [15:0] kd_reg;
    logic [31:0] clock_reg;
    logic [31:0] scale_reg;

    logic        push;
    job_t        push_data;
    logic        queue_full;
    logic        pop;
    logic        queue_empty;
    job_t        pop_data;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= KP_RESET;
            ki_reg    <= KI_RESET;
            kd_reg    <= KD_RESET;
            clock_reg <= CLOCK_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KP:    kp_reg    <= cfg_data[15:0];
                REG_KI:    ki_reg    <= cfg_data[15:0];
                REG_KD:    kd_reg    <= cfg_data[15:0];
                REG_CLOCK: clock_reg <= cfg_data;
                REG_SCALE: scale_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    epps_front #(
        .COUNTER_MODULUS (COUNTER_MODULUS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .capture_value  (capture_value),
        .speed_setpoint (speed_setpoint),
        .direction      (direction),
        .push           (push),
        .push_data      (push_data),
        .queue_full     (queue_full)
    );

    epps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .empty     (queue_empty),
        .pop_data  (pop_data)
    );

    epps_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_empty     (queue_empty),
        .job             (pop_data),
        .pop             (pop),
        .kp_gain         (kp_reg),
        .ki_gain         (ki_reg),
        .kd_gain         (kd_reg),
        .timer_clk_hz    (clock_reg),
        .speed_scale     (scale_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .drive_value     (drive_value),
        .direction_out   (direction_out),
        .period_count    (period_count),
        .phase_frequency (phase_frequency),
        .speed_meas      (speed_meas)
    );

endmodule

[bench/tb_encoder_period_pid_speed.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_period_pid_speed: self-checking bench for the encoder speed loop
// Feeds timer events (captures, overflows, ignored codes) through the input
// channel under random idling and stalls, models capture pairing, period,
// frequency, speed and the PID step in the bench, and checks every result
// field against the oldest prediction. Gains, clock and scale are changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_encoder_period_pid_speed;
    import epps_pkg::*;

    typedef struct {
        logic [1:0]  ev_mode;
        logic [31:0] cap;
        logic [15:0] target;
        logic        dir;
    } event_t;

    typedef struct {
        logic [31:0] drive;
        logic        dir;
        logic [31:0] period;
        logic [31:0] freq;
        logic [15:0] speed;
    } speed_result_t;

    localparam int unsigned CYCLE_LIMIT = 600000;

    // codes outside the defined sets
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] mode = MODE_PHASE_B;
    logic [31:0] capture_value = '0;
    logic [15:0] speed_setpoint = '0;
    logic direction = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] drive_value;
    logic direction_out;
    logic [31:0] period_count;
    logic [31:0] phase_frequency;
    logic [15:0] speed_meas;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // bench copy of registers and loop state
    logic [15:0] kp_q, ki_q, kd_q;
    logic [31:0] clock_q, scale_q;
    logic        pair_open;
    logic [31:0] first_cap_q;
    logic [31:0] ovf_count_q;
    int          integral_q;
    int          prev_error_q;

    event_t        pending_events[$];
    speed_result_t expected_results[$];
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            errors = 0;
    int unsigned   cycles = 0;

    encoder_period_pid_speed u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .capture_value(capture_value),
        .speed_setpoint(speed_setpoint), .direction(direction),
        .out_valid(out_valid), .out_stall(out_stall),
        .drive_value(drive_value), .direction_out(direction_out),
        .period_count(period_count), .phase_frequency(phase_frequency),
        .speed_meas(speed_meas),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp32(longint v);
        if (v > longint'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
        if (v < -longint'(64'h80000000))
            return 32'sh80000000;
        return int'(v);
    endfunction

    // advance the loop model by one event; push a result when a pair closes
    task automatic track_event(input event_t ev);
        logic [31:0] second, period, freq;
        logic [63:0] prod;
        logic [15:0] speed;
        int err, deriv;
        longint sum;
        speed_result_t r;
        if (ev.ev_mode == MODE_OVERFLOW)
        begin
            ovf_count_q = ovf_count_q + 1;
        end
        else if (ev.ev_mode == MODE_PHASE_A)
        begin
            if (!pair_open)
            begin
                first_cap_q = ev.cap;
                ovf_count_q = '0;
                pair_open = 1'b1;
            end
            else
            begin
                second = ev.cap + 32'(64'(ovf_count_q) * 64'(COUNTER_MODULUS_DEFAULT));
                period = second - first_cap_q;
                freq = (period == 0) ? 32'hFFFFFFFF : clock_q / period;
                prod = (64'(freq) * 64'(scale_q)) >> 16;
                speed = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
                err = int'({16'd0, ev.target}) - int'({16'd0, speed});
                deriv = err - prev_error_q;
                integral_q = clamp32(longint'(integral_q) + longint'(err));
                sum = longint'(kp_q) * err + longint'(ki_q) * integral_q
                    + longint'(kd_q) * deriv;
                prev_error_q = err;
                r.drive = clamp32((sum + 2048) >>> 12);
                r.dir = ev.dir;
                r.period = period;
                r.freq = freq;
                r.speed = speed;
                expected_results.push_back(r);
                ovf_count_q = '0;
                pair_open = 1'b0;
            end
        end
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $time);
        errors++;
    endtask

    // driver: present pending events, hold while stalled
    always @(posedge clk)
    begin
        event_t ev;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                ev.ev_mode = mode;
                ev.cap = capture_value;
                ev.target = speed_setpoint;
                ev.dir = direction;
                track_event(ev);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    ev = pending_events.pop_front();
                    in_valid <= 1'b1;
                    mode <= ev.ev_mode;
                    capture_value <= ev.cap;
                    speed_setpoint <= ev.target;
                    direction <= ev.dir;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transfer, stall at random
    always @(posedge clk)
    begin
        speed_result_t w;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result transfer at %0t", $time);
                    errors++;
                end
                else
                begin
                    w = expected_results.pop_front();
                    if (drive_value !== w.drive)
                        report("drive_value", drive_value, w.drive);
                    if (direction_out !== w.dir)
                        report("direction_out", 32'(direction_out), 32'(w.dir));
                    if (period_count !== w.period)
                        report("period_count", period_count, w.period);
                    if (phase_frequency !== w.freq)
                        report("phase_frequency", phase_frequency, w.freq);
                    if (speed_meas !== w.speed)
                        report("speed_meas", 32'(speed_meas), 32'(w.speed));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KP:    kp_q = val[15:0];
            REG_KI:    ki_q = val[15:0];
            REG_KD:    kd_q = val[15:0];
            REG_CLOCK: clock_q = val;
            REG_SCALE: scale_q = val;
            default:   ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [31:0] clk_hz,
                             input logic [31:0] scale);
        write_reg(REG_KP, {16'(~kp), kp});
        write_reg(REG_KI, {16'hA5A5, ki});
        write_reg(REG_KD, 32'(kd));
        write_reg(REG_CLOCK, clk_hz);
        write_reg(REG_SCALE, scale);
    endtask

    task automatic add_event(input logic [1:0] m, input logic [31:0] cap,
                             input logic [15:0] tgt, input logic dir);
        event_t ev;
        ev.ev_mode = m;
        ev.cap = cap;
        ev.target = tgt;
        ev.dir = dir;
        pending_events.push_back(ev);
    endtask

    function automatic logic [15:0] pick_target();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed capture pairs with overflows; some noise events
    task automatic add_random(input int count);
        int n;
        int k;
        logic [31:0] first, delta;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_event(2'($urandom), $urandom, pick_target(), 1'($urandom));
                n++;
            end
            else
            begin
                first = $urandom;
                add_event(MODE_PHASE_A, first, pick_target(), 1'($urandom));
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
                repeat (k)
                    add_event(MODE_OVERFLOW, $urandom, pick_target(), 1'($urandom));
                if ($urandom_range(0, 4) == 0)
                    add_event(MODE_PHASE_B, $urandom, pick_target(), 1'($urandom));
                case ($urandom_range(0, 4))
                    0: delta = $urandom_range(0, 100);
                    1: delta = $urandom_range(100, 70000);
                    2: delta = $urandom_range(70000, 50000000);
                    3: delta = $urandom;
                    default: delta = 32'(-$urandom_range(0, 65536 * k + 10));
                endcase
                add_event(MODE_PHASE_A, first + delta, pick_target(), 1'($urandom));
                n += k + 2;
            end
        end
    endtask

    // hold until every queued event is taken and every result is back
    task automatic drain();
        @(posedge clk);
        while (pending_events.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    initial
    begin
        kp_q = KP_RESET;
        ki_q = KI_RESET;
        kd_q = KD_RESET;
        clock_q = CLOCK_RESET;
        scale_q = SCALE_RESET;
        pair_open = 1'b0;
        first_cap_q = '0;
        ovf_count_q = '0;
        integral_q = 0;
        prev_error_q = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed: ignored codes, early overflows, zero period, wraps, saturation
        send_idle_pct = 36;
        recv_idle_pct = 67;
        add_event(MODE_OVERFLOW, 32'hFFFFFFFF, 16'hFFFF, 1'b1);
        add_event(MODE_PHASE_B, 32'h12345678, 16'd100, 1'b1);
        add_event(MODE_UNUSED, 32'hFFFFFFFF, 16'hFFFF, 1'b1);
        add_event(MODE_PHASE_A, 32'd1000, 16'd500, 1'b1);
        add_event(MODE_PHASE_A, 32'd1000, 16'd500, 1'b1);
        add_event(MODE_PHASE_A, 32'hFFFFFF00, 16'h0000, 1'b0);
        add_event(MODE_OVERFLOW, 32'd0, 16'd0, 1'b0);
        add_event(MODE_OVERFLOW, 32'd0, 16'd0, 1'b0);
        add_event(MODE_PHASE_B, 32'd7, 16'd7, 1'b1);
        add_event(MODE_PHASE_A, 32'h00000100, 16'hFFFF, 1'b1);
        add_event(MODE_PHASE_A, 32'd0, 16'hFFFF, 1'b0);
        add_event(MODE_PHASE_A, 32'd100000000, 16'd1, 1'b1);
        add_event(MODE_PHASE_A, 32'd0, 16'd0, 1'b1);
        add_event(MODE_PHASE_A, 32'hFFFFFFFF, 16'd0, 1'b0);
        add_event(MODE_PHASE_A, 32'd50000, 16'd3000, 1'b1);
        add_event(MODE_PHASE_A, 32'd80000, 16'd3000, 1'b0);
        drain();
        add_random(400);
        drain();

        // extremes: maximum gains, slowest clock, no scale
        send_idle_pct = 67;
        recv_idle_pct = 36;
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd1, 32'd0);
        write_reg(REG_SPARE_LO, 32'hFFFFFFFF);
        write_reg(REG_SPARE_HI, 32'h0);
        add_event(MODE_PHASE_A, 32'd5, 16'hFFFF, 1'b1);
        add_event(MODE_PHASE_A, 32'd5, 16'hFFFF, 1'b1);
        add_event(MODE_PHASE_A, 32'd5, 16'hFFFF, 1'b0);
        add_event(MODE_PHASE_A, 32'd6, 16'hFFFF, 1'b0);
        add_random(400);
        drain();

        // fastest clock, maximum scale, zero gains
        write_all(16'h0000, 16'h0000, 16'h0000, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_random(150);
        drain();

        // random settings, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(1000, 200000000), $urandom_range(0, 1 << 20));
        add_random(350);
        drain();
        write_all(16'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom);
        add_random(300);
        drain();

        if (errors == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
